[rtl/bsa_pkg.sv]
// Package: item layout, microinstruction codes and the ALU function of the bit-slice ALU.
`timescale 1ns / 1ps
`default_nettype none
package bsa_pkg;

    localparam int NIB_W     = 4;
    localparam int RF_DEPTH  = 16;
    localparam int RF_ADDR_W = 4;
    localparam int IN_W      = 32;
    localparam int OUT_W     = 8;

    typedef logic [NIB_W-1:0] nib_t;

    typedef enum logic [2:0] {
        SRC_AQ = 3'd0,
        SRC_AB = 3'd1,
        SRC_ZQ = 3'd2,
        SRC_ZB = 3'd3,
        SRC_ZA = 3'd4,
        SRC_DA = 3'd5,
        SRC_DQ = 3'd6,
        SRC_DZ = 3'd7
    } src_t;

    typedef enum logic [2:0] {
        FN_ADD  = 3'd0,
        FN_SUBR = 3'd1,
        FN_SUBS = 3'd2,
        FN_OR   = 3'd3,
        FN_AND  = 3'd4,
        FN_NOTRS = 3'd5,
        FN_XOR  = 3'd6,
        FN_XNOR = 3'd7
    } fn_t;

    typedef enum logic [2:0] {
        DST_QREG = 3'd0,
        DST_NOP  = 3'd1,
        DST_RAMA = 3'd2,
        DST_RAMF = 3'd3,
        DST_RAMQD = 3'd4,
        DST_RAMD = 3'd5,
        DST_RAMQU = 3'd6,
        DST_RAMU = 3'd7
    } dst_t;

    typedef struct packed {
        dst_t dst;
        fn_t  fn;
        src_t src;
    } cmd_t;

    // Input item as packed in s_tdata, lowest field in the lowest bits.
    typedef struct packed {
        logic [4:0] pad;
        logic       output_disable;
        logic       ram_shift_in_low;
        logic       q_shift_in_low;
        logic       ram_shift_in_high;
        logic       q_shift_in_high;
        logic       carry_in;
        cmd_t       command;
        nib_t       direct_data;
        nib_t       addr_b;
        nib_t       addr_a;
    } in_item_t;

    function automatic nib_t alu_f(input fn_t fn, input nib_t r, input nib_t s,
                                   input logic cin);
        logic [NIB_W:0] sum;
        nib_t           f;
        sum = '0;
        case (fn)
            FN_ADD:   sum = {1'b0, r} + {1'b0, s} + {{NIB_W{1'b0}}, cin};
            FN_SUBR:  sum = {1'b0, s} + {1'b0, ~r} + {{NIB_W{1'b0}}, cin};
            FN_SUBS:  sum = {1'b0, r} + {1'b0, ~s} + {{NIB_W{1'b0}}, cin};
            default:  sum = '0;
        endcase
        case (fn)
            FN_ADD, FN_SUBR, FN_SUBS: f = sum[NIB_W-1:0];
            FN_OR:    f = r | s;
            FN_AND:   f = r & s;
            FN_NOTRS: f = ~r & s;
            FN_XOR:   f = r ^ s;
            FN_XNOR:  f = ~(r ^ s);
            default:  f = '0;
        endcase
        return f;
    endfunction

endpackage
`default_nettype wire

[rtl/bit_slice_alu_4bit.sv]
// Top level: 4-bit bit-slice ALU with a sixteen-word register file and a Q register.
//
// The block takes one microinstruction item per clock while its output flows, and returns one
// result item for each, in order. A result passes from the execute register into the output
// register before it is presented on m_tdata. The execute register advances whenever the
// output register is empty or being taken. The register file sits in a synchronous memory
// with two read ports and one write port. Operands are read in the accept cycle, and the
// result is written back when its item leaves the execute register. A read of the entry that
// is being written in that same cycle takes the write data through a forward path. Entries that
// were never written read as their own address. The result waits in an output register, so a
// new item is taken while an earlier result is not yet taken.
`timescale 1ns / 1ps
`default_nettype none
module bit_slice_alu_4bit (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    // addr_a, addr_b, direct_data, command, carry_in, q_shift_in_high,
    // ram_shift_in_high, q_shift_in_low, ram_shift_in_low, output_disable, zero fill
    input  wire logic [bsa_pkg::IN_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    // y_value, y_driven, zero fill
    output logic [bsa_pkg::OUT_W-1:0]     m_tdata
);
    import bsa_pkg::*;

    in_item_t              in_item;
    logic                  s_acc;
    logic                  s1_go;

    logic                  s1_valid_reg;
    in_item_t              s1_item_reg;

    nib_t                  rf_mem [RF_DEPTH];
    logic [RF_DEPTH-1:0]   rf_valid_reg;
    nib_t                  rd_a_reg;
    nib_t                  rd_b_reg;
    logic                  ok_a_reg;
    logic                  ok_b_reg;
    logic                  fwd_a_reg;
    logic                  fwd_b_reg;
    nib_t                  fwd_data_reg;

    nib_t                  q_reg;
    nib_t                  q_next;
    logic                  wr_en;
    nib_t                  wr_data;

    nib_t                  ra;
    nib_t                  rb;
    nib_t                  op_r;
    nib_t                  op_s;
    nib_t                  f_val;
    nib_t                  y_val;

    logic                  m_tvalid_reg;
    nib_t                  y_value_reg;
    logic                  y_driven_reg;

    assign in_item  = in_item_t'(s_tdata);
    assign s1_go    = s1_valid_reg && (!m_tvalid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_go;
    assign s_acc    = s_tvalid && s_tready;

    // Forward the write of this cycle, then memory data, then the reset value.
    always_comb
    begin
        if (fwd_a_reg)
            ra = fwd_data_reg;
        else if (ok_a_reg)
            ra = rd_a_reg;
        else
            ra = s1_item_reg.addr_a;
        if (fwd_b_reg)
            rb = fwd_data_reg;
        else if (ok_b_reg)
            rb = rd_b_reg;
        else
            rb = s1_item_reg.addr_b;
    end

    always_comb
    begin
        case (s1_item_reg.command.src)
            SRC_AQ:  begin op_r = ra;                      op_s = q_reg; end
            SRC_AB:  begin op_r = ra;                      op_s = rb;    end
            SRC_ZQ:  begin op_r = '0;                      op_s = q_reg; end
            SRC_ZB:  begin op_r = '0;                      op_s = rb;    end
            SRC_ZA:  begin op_r = '0;                      op_s = ra;    end
            SRC_DA:  begin op_r = s1_item_reg.direct_data; op_s = ra;    end
            SRC_DQ:  begin op_r = s1_item_reg.direct_data; op_s = q_reg; end
            default: begin op_r = s1_item_reg.direct_data; op_s = '0;    end
        endcase
    end

    assign f_val = alu_f(s1_item_reg.command.fn, op_r, op_s, s1_item_reg.carry_in);
    assign y_val = (s1_item_reg.command.dst == DST_RAMA) ? ra : f_val;

    always_comb
    begin
        q_next  = q_reg;
        wr_en   = 1'b0;
        wr_data = f_val;
        case (s1_item_reg.command.dst)
            DST_QREG:  q_next = f_val;
            DST_NOP:   q_next = q_reg;
            DST_RAMA,
            DST_RAMF:  wr_en = 1'b1;
            DST_RAMQD:
            begin
                q_next  = {s1_item_reg.q_shift_in_high, q_reg[NIB_W-1:1]};
                wr_en   = 1'b1;
                wr_data = {s1_item_reg.ram_shift_in_high, f_val[NIB_W-1:1]};
            end
            DST_RAMD:
            begin
                wr_en   = 1'b1;
                wr_data = {s1_item_reg.ram_shift_in_high, f_val[NIB_W-1:1]};
            end
            DST_RAMQU:
            begin
                q_next  = {q_reg[NIB_W-2:0], s1_item_reg.q_shift_in_low};
                wr_en   = 1'b1;
                wr_data = {f_val[NIB_W-2:0], s1_item_reg.ram_shift_in_low};
            end
            default:
            begin
                wr_en   = 1'b1;
                wr_data = {f_val[NIB_W-2:0], s1_item_reg.ram_shift_in_low};
            end
        endcase
        if (!s1_go)
        begin
            q_next = q_reg;
            wr_en  = 1'b0;
        end
    end

    // Register file memory: one write port, two registered read ports.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            rf_mem[s1_item_reg.addr_b] <= wr_data;
        if (s_acc)
        begin
            rd_a_reg <= rf_mem[in_item.addr_a];
            rd_b_reg <= rf_mem[in_item.addr_b];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            s1_item_reg  <= in_item;
            fwd_data_reg <= wr_data;
        end
        if (s1_go)
        begin
            y_value_reg  <= s1_item_reg.output_disable ? '0 : y_val;
            y_driven_reg <= !s1_item_reg.output_disable;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
            rf_valid_reg <= '0;
            q_reg        <= '1;
            ok_a_reg     <= 1'b0;
            ok_b_reg     <= 1'b0;
            fwd_a_reg    <= 1'b0;
            fwd_b_reg    <= 1'b0;
        end
        else
        begin
            q_reg <= q_next;
            if (wr_en)
                rf_valid_reg[s1_item_reg.addr_b] <= 1'b1;
            if (s_acc)
            begin
                ok_a_reg  <= rf_valid_reg[in_item.addr_a];
                ok_b_reg  <= rf_valid_reg[in_item.addr_b];
                fwd_a_reg <= wr_en && (s1_item_reg.addr_b == in_item.addr_a);
                fwd_b_reg <= wr_en && (s1_item_reg.addr_b == in_item.addr_b);
            end
            if (s_acc)
                s1_valid_reg <= 1'b1;
            else if (s1_go)
                s1_valid_reg <= 1'b0;
            if (s1_go)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(OUT_W - NIB_W - 1){1'b0}}, y_driven_reg, y_value_reg};

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (s1_valid_reg && m_tvalid_reg && !m_tready))
        else $error("input stalled with room in the pipeline");

    a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
        s_acc |=> s1_valid_reg)
        else $error("accepted item did not reach the execute stage");

    a_forward_needs_write: assert property (@(posedge clk) disable iff (!rst_n)
        s_acc && wr_en && (s1_item_reg.addr_b == in_item.addr_a) |=> fwd_a_reg)
        else $error("read of entry under write missed the forward");

    a_disabled_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[NIB_W]) |-> (m_tdata[NIB_W-1:0] == '0))
        else $error("undriven Y carries a nonzero value");

endmodule
`default_nettype wire
